>>> rtl/ctkvs_pkg.sv
package ctkvs_pkg;

	// Store geometry.
	localparam int ENTRIES = 64;
	localparam int DIM     = 64;

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int DAW     = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int LEN_W   = $clog2(DIM + 1);
	localparam int EM_AW   = (ENTRIES * DIM > 1) ? $clog2(ENTRIES * DIM) : 1;

	// Accumulator widths: each product is at most 2^30 in magnitude.
	localparam int NRM_W   = $clog2(DIM) + 31;
	localparam int DOT_W   = NRM_W + 1;
	localparam int PROD_W  = 2 * NRM_W;

	// Quotient bits; the score magnitude never exceeds 2^15 + small slack.
	localparam int QUO_W   = 17;
	localparam int SCORE_W = 16;
	localparam int OIDX_W  = 6;
	localparam int TOPK_W  = 7;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

	// Command codes carried on s_axis_tuser.
	localparam logic CMD_ENTRY = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [NRM_W-1:0]        na;
		logic [NRM_W-1:0]        nb;
	} score_req_t;

	typedef enum logic [4:0] {
		CD_IDLE = 5'b00001,
		CD_MUL  = 5'b00010,
		CD_SQRT = 5'b00100,
		CD_DIV  = 5'b01000,
		CD_FIN  = 5'b10000
	} cd_state_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LEN  = 7'b0000010,
		ST_MAC  = 7'b0000100,
		ST_CALC = 7'b0001000,
		ST_SEL  = 7'b0010000,
		ST_EMIT = 7'b0100000,
		ST_NONE = 7'b1000000
	} vs_state_t;

endpackage

>>> rtl/ctkvs_cosdiv.sv
module ctkvs_cosdiv
	import ctkvs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  score_req_t                req,
	output logic                      done,
	output logic signed [SCORE_W-1:0] score
);

	localparam int STEP_W = $clog2(PROD_W + 1);
	localparam int DRM_W  = NRM_W + 15;
	localparam int DSH_W  = NRM_W + 17;

	cd_state_t st_q;
	logic [STEP_W-1:0] cnt_q;
	logic neg_q, zero_q, done_q;
	logic [NRM_W-1:0] mag_q, mplier_q, root_q;
	logic [PROD_W-1:0] mcand_q, prod_q, rad_q;
	logic [NRM_W+1:0] rem_q;
	logic [DRM_W-1:0] drem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic signed [SCORE_W-1:0] score_q;

	logic [PROD_W-1:0] prod_nx;
	logic [NRM_W+3:0] rem2, trial;
	logic [NRM_W+1:0] rem_nx;
	logic [NRM_W-1:0] root_nx;
	logic div_ge;

	always_comb begin
		prod_nx = mplier_q[0] ? prod_q + mcand_q : prod_q;
		rem2    = {rem_q, rad_q[PROD_W-1:PROD_W-2]};
		trial   = {2'b00, root_q, 2'b01};
		if (rem2 >= trial) begin
			rem_nx  = (NRM_W + 2)'(rem2 - trial);
			root_nx = {root_q[NRM_W-2:0], 1'b1};
		end else begin
			rem_nx  = rem2[NRM_W+1:0];
			root_nx = {root_q[NRM_W-2:0], 1'b0};
		end
		div_ge = {2'b00, drem_q} >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= CD_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				CD_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						st_q  <= (req.na == '0 || req.nb == '0) ? CD_FIN : CD_MUL;
					end
				end
				CD_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(NRM_W - 1)) begin
						cnt_q <= '0;
						st_q  <= CD_SQRT;
					end
				end
				CD_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(NRM_W - 1)) begin
						cnt_q <= '0;
						st_q  <= CD_DIV;
					end
				end
				CD_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(QUO_W - 1)) begin
						st_q <= CD_FIN;
					end
				end
				CD_FIN: begin
					done_q <= 1'b1;
					st_q   <= CD_IDLE;
				end
				default: st_q <= CD_IDLE;
			endcase
		end
	end

	// Datapath: shift-add product, digit-by-digit root, restoring division.
	always_ff @(posedge clk) begin
		case (st_q)
			CD_IDLE: begin
				if (start) begin
					neg_q    <= req.dot[DOT_W-1];
					zero_q   <= (req.na == '0 || req.nb == '0);
					mag_q    <= NRM_W'(req.dot[DOT_W-1] ? -req.dot : req.dot);
					mcand_q  <= PROD_W'(req.na);
					mplier_q <= req.nb;
					prod_q   <= '0;
				end
			end
			CD_MUL: begin
				prod_q   <= prod_nx;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[NRM_W-1:1]};
				rad_q    <= prod_nx;
				rem_q    <= '0;
				root_q   <= '0;
			end
			CD_SQRT: begin
				rem_q  <= rem_nx;
				root_q <= root_nx;
				rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
				dsh_q  <= {1'b0, root_nx, 16'd0};
				drem_q <= {mag_q, 15'd0};
				quo_q  <= '0;
			end
			CD_DIV: begin
				if (div_ge) begin
					drem_q <= DRM_W'({2'b00, drem_q} - dsh_q);
				end
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
				dsh_q <= {1'b0, dsh_q[DSH_W-1:1]};
			end
			CD_FIN: begin
				if (zero_q) begin
					score_q <= '0;
				end else if (neg_q) begin
					score_q <= (quo_q > QUO_W'(32768)) ? SCORE_MIN
					                                  : SCORE_W'(-quo_q);
				end else begin
					score_q <= (quo_q > QUO_W'(32767)) ? SCORE_MAX
					                                  : SCORE_W'(quo_q);
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign score = score_q;

endmodule

>>> rtl/cosine_topk_vector_search.sv
// Cosine similarity top-k search over a small vector store.
// Input channel s_axis: one vector component per transfer. tuser selects the
// target (0 = entry being inserted, 1 = query), tlast closes the vector, and
// tdata carries the Q1.15 component and, on the closing query transfer, top_k.
// Output channel m_axis: one transfer per hit, best score first, ties in
// insertion order; tlast marks the last hit of a query, tuser is the hit flag.
// A query with no hit (top_k zero or an empty store) yields one transfer with
// tuser low.
// Component transfers are taken one per cycle while the block is idle. After the
// closing query transfer s_axis_tready stays low while every stored entry is
// scored, by a multiply-accumulate walk over the entry memory and then by the
// shared bit-serial product, square-root and divide unit. Selection then
// scans the score memory once per hit.
// A stalled receiver holds the output register and stops the selection; the
// input side reopens after the last hit has been loaded into that register.
// Reset empties the store and the query; the memories hold no reset value.
module cosine_topk_vector_search
	import ctkvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [15:0] value, [22:16] top_k, [23] zero
	input  logic        s_axis_tuser,  // [0] command
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [5:0] entry_index, [21:6] score, [23:22] zero
	output logic        m_axis_tuser,  // [0] hit_valid
	output logic        m_axis_tlast   // last_res
);

	// Storage.
	logic signed [SCORE_W-1:0] emem [ENTRIES*DIM];
	logic [LEN_W-1:0]          lmem [ENTRIES];
	logic signed [SCORE_W-1:0] qmem [DIM];
	logic signed [SCORE_W-1:0] smem [ENTRIES];

	vs_state_t st_q;
	logic [CNT_W-1:0] cnt_q, k_q, pass_q, scan_q;
	logic [LEN_W-1:0] wp_q, qlen_q, i_q, len_rd_q;
	logic [IDX_W-1:0] e_q, best_q;
	logic [ENTRIES-1:0] picked_q;
	logic found_q;
	logic signed [SCORE_W-1:0] best_score_q;

	// Scoring pipeline: read stage, product stage, accumulate.
	logic v_s1, v_s2;
	logic signed [SCORE_W-1:0] qrd_s1, erd_s1;
	logic signed [31:0] pd_s2, pa_s2, pb_s2;
	logic signed [DOT_W-1:0] dot_q;
	logic [NRM_W-1:0] na_q, nb_q;

	// Selection pipeline.
	logic sv_s1;
	logic [IDX_W-1:0] sidx_s1;
	logic signed [SCORE_W-1:0] srd_s1;

	// Output register.
	logic ovalid_q, ohit_q, olast_q;
	logic [OIDX_W-1:0] oidx_q;
	logic signed [SCORE_W-1:0] oscore_q;

	logic in_fire, entry_fire, query_fire, out_free, oload;
	logic issue, sissue, cd_start, cd_done, is_last_pass;
	logic [LEN_W-1:0] nlen;
	logic [TOPK_W-1:0] top_k_in;
	logic [CNT_W-1:0] keff;
	logic signed [SCORE_W-1:0] value_in, cd_score;
	score_req_t cd_req;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign entry_fire = in_fire && (s_axis_tuser == CMD_ENTRY);
	assign query_fire = in_fire && (s_axis_tuser == CMD_QUERY);
	assign value_in = s_axis_tdata[15:0];
	assign top_k_in = s_axis_tdata[22:16];
	assign out_free = !ovalid_q || m_axis_tready;
	// The output register takes a new result in this cycle.
	assign oload    = out_free && (st_q inside {ST_EMIT, ST_NONE});
	assign nlen     = (len_rd_q < qlen_q) ? len_rd_q : qlen_q;
	assign issue    = (st_q == ST_MAC) && (i_q < nlen);
	assign sissue   = (st_q == ST_SEL) && (scan_q < cnt_q);
	assign cd_start = (st_q == ST_MAC) && !issue && !v_s1 && !v_s2;
	assign is_last_pass = (pass_q + 1'b1 == k_q);

	// top_k is clamped to the number of stored entries.
	always_comb begin
		if (TOPK_W'(cnt_q) < top_k_in) begin
			keff = cnt_q;
		end else begin
			keff = CNT_W'(top_k_in);
		end
	end

	assign cd_req.dot = dot_q;
	assign cd_req.na  = na_q;
	assign cd_req.nb  = nb_q;

	ctkvs_cosdiv u_cosdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.req    (cd_req),
		.done   (cd_done),
		.score  (cd_score)
	);

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (entry_fire && cnt_q < CNT_W'(ENTRIES) && wp_q < LEN_W'(DIM)) begin
			emem[EM_AW'(int'(cnt_q) * DIM + int'(wp_q))] <= value_in;
		end
		if (entry_fire && s_axis_tlast && cnt_q < CNT_W'(ENTRIES)) begin
			lmem[IDX_W'(cnt_q)] <= (wp_q < LEN_W'(DIM)) ? wp_q + 1'b1 : wp_q;
		end
		if (query_fire && qlen_q < LEN_W'(DIM)) begin
			qmem[DAW'(qlen_q)] <= value_in;
		end
		if (st_q == ST_CALC && cd_done) begin
			smem[e_q] <= cd_score;
		end
		len_rd_q <= lmem[e_q];
		qrd_s1   <= qmem[DAW'(i_q)];
		erd_s1   <= emem[EM_AW'(int'(e_q) * DIM + int'(i_q))];
		srd_s1   <= smem[IDX_W'(scan_q)];
		sidx_s1  <= IDX_W'(scan_q);
		pd_s2    <= qrd_s1 * erd_s1;
		pa_s2    <= qrd_s1 * qrd_s1;
		pb_s2    <= erd_s1 * erd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cnt_q        <= '0;
			wp_q         <= '0;
			qlen_q       <= '0;
			k_q          <= '0;
			pass_q       <= '0;
			scan_q       <= '0;
			i_q          <= '0;
			e_q          <= '0;
			best_q       <= '0;
			best_score_q <= '0;
			picked_q     <= '0;
			found_q      <= 1'b0;
			dot_q        <= '0;
			na_q         <= '0;
			nb_q         <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			sv_s1        <= 1'b0;
			ovalid_q     <= 1'b0;
			ohit_q       <= 1'b0;
			olast_q      <= 1'b0;
			oidx_q       <= '0;
			oscore_q     <= '0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			sv_s1 <= sissue;
			if (m_axis_tready && !oload) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (entry_fire) begin
						// A closing transfer always rewinds the fill position.
						if (s_axis_tlast) begin
							wp_q <= '0;
						end else if (cnt_q < CNT_W'(ENTRIES) && wp_q < LEN_W'(DIM)) begin
							wp_q <= wp_q + 1'b1;
						end
						if (s_axis_tlast && cnt_q < CNT_W'(ENTRIES)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (query_fire) begin
						if (qlen_q < LEN_W'(DIM)) begin
							qlen_q <= qlen_q + 1'b1;
						end
						if (s_axis_tlast) begin
							k_q      <= keff;
							pass_q   <= '0;
							e_q      <= '0;
							picked_q <= '0;
							st_q     <= (keff == '0) ? ST_NONE : ST_LEN;
						end
					end
				end
				ST_LEN: begin
					// Length read lands this cycle; clear the accumulators.
					i_q   <= '0;
					dot_q <= '0;
					na_q  <= '0;
					nb_q  <= '0;
					st_q  <= ST_MAC;
				end
				ST_MAC: begin
					if (issue) begin
						i_q <= i_q + 1'b1;
					end
					if (v_s2) begin
						dot_q <= dot_q + DOT_W'(pd_s2);
						na_q  <= na_q + NRM_W'($unsigned(pa_s2));
						nb_q  <= nb_q + NRM_W'($unsigned(pb_s2));
					end
					if (cd_start) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (cd_done) begin
						if (CNT_W'(e_q) + 1'b1 == cnt_q) begin
							qlen_q  <= '0;
							scan_q  <= '0;
							found_q <= 1'b0;
							st_q    <= ST_SEL;
						end else begin
							e_q  <= e_q + 1'b1;
							st_q <= ST_LEN;
						end
					end
				end
				ST_SEL: begin
					if (sissue) begin
						scan_q <= scan_q + 1'b1;
					end
					// Strict compare keeps the earliest entry among equals.
					if (sv_s1 && !picked_q[sidx_s1] && (!found_q || srd_s1 > best_score_q)) begin
						found_q      <= 1'b1;
						best_q       <= sidx_s1;
						best_score_q <= srd_s1;
					end
					if (!sissue && !sv_s1) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ovalid_q         <= 1'b1;
						ohit_q           <= 1'b1;
						olast_q          <= is_last_pass;
						oidx_q           <= OIDX_W'(best_q);
						oscore_q         <= best_score_q;
						picked_q[best_q] <= 1'b1;
						pass_q           <= pass_q + 1'b1;
						scan_q           <= '0;
						found_q          <= 1'b0;
						st_q             <= is_last_pass ? ST_IDLE : ST_SEL;
					end
				end
				ST_NONE: begin
					qlen_q <= '0;
					if (out_free) begin
						ovalid_q <= 1'b1;
						ohit_q   <= 1'b0;
						olast_q  <= 1'b1;
						oidx_q   <= '0;
						oscore_q <= '0;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {2'b00, oscore_q, oidx_q};
	assign m_axis_tuser  = ohit_q;
	assign m_axis_tlast  = olast_q;

	// The store never counts past its capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond capacity");

	// The scoring unit only finishes while the sequencer waits for it.
	a_cd_done: assert property (@(posedge clk) disable iff (!arst_n)
		cd_done |-> st_q == ST_CALC)
		else $error("score unit finished outside its wait state");

	// No more entries are marked as reported than the store holds.
	a_picked: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(picked_q) <= int'(cnt_q))
		else $error("more hits reported than entries stored");

	// A no-hit result always closes its run.
	a_nohit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !ohit_q) |-> olast_q)
		else $error("no-hit result without end mark");

	// Selection starts only after the query length has been consumed.
	a_sel_qlen: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SEL) |-> (qlen_q == '0))
		else $error("query length left over during selection");

endmodule

>>> tb/sv/cosine_topk_vector_search_test.sv
module cosine_topk_vector_search_test
	import ctkvs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// A run of 500 items can hold a few dozen queries against a full store,
	// each needing scoring and selection; the limit below is several times the
	// slowest correct run.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 500;

	typedef struct {
		logic [5:0]         entry_index;
		logic signed [15:0] score;
		logic               hit_valid;
		logic               last_res;
	} hit_t;

	// Shadow copy of the vector store. It scores every stored entry when a
	// query closes and queues the hits that the block must return, best first.
	class topk_search_scoreboard;
		logic signed [15:0] entry_vec[ENTRIES][DIM];
		int                 entry_len[ENTRIES];
		int                 stored_count;
		int                 fill_position;
		logic signed [15:0] query_vec[DIM];
		int                 query_len;
		hit_t               pending_hits[$];
		int                 errors;

		function new();
			stored_count = 0;
			fill_position = 0;
			query_len = 0;
			errors = 0;
		endfunction

		// Cosine score in Q1.15: trunc(dot * 2^15 / floor(sqrt(na * nb))).
		function logic signed [15:0] cosine_of(int e);
			longint dot;
			longint unsigned na, nb, den, mag, quot;
			bit [127:0] prod, sq;
			bit [63:0] cand;
			int n, r;
			dot = 0;
			na = 0;
			nb = 0;
			n = (entry_len[e] < query_len) ? entry_len[e] : query_len;
			for (int i = 0; i < n; i++) begin
				dot += longint'(query_vec[i]) * longint'(entry_vec[e][i]);
				na += longint'(query_vec[i]) * longint'(query_vec[i]);
				nb += longint'(entry_vec[e][i]) * longint'(entry_vec[e][i]);
			end
			if (na == 0 || nb == 0)
				return 16'sd0;
			prod = {64'd0, na} * {64'd0, nb};
			den = 0;
			for (int b = 63; b >= 0; b--) begin
				cand = den | (64'd1 << b);
				sq = {64'd0, cand} * {64'd0, cand};
				if (sq <= prod)
					den = cand;
			end
			mag = (dot < 0) ? -dot : dot;
			quot = (mag << 15) / den;
			if (dot < 0)
				r = (quot > 32768) ? -32768 : -int'(quot);
			else
				r = (quot > 32767) ? 32767 : int'(quot);
			return r[15:0];
		endfunction

		function void note_transfer(logic cmd, logic signed [15:0] value, logic last,
				logic [6:0] top_k);
			logic signed [15:0] scores[ENTRIES];
			bit taken[ENTRIES];
			int want, best;
			hit_t h;
			if (cmd == CMD_ENTRY) begin
				// A full store drops components; the closing transfer still
				// rewinds the fill position.
				if (stored_count < ENTRIES) begin
					if (fill_position < DIM) begin
						entry_vec[stored_count][fill_position] = value;
						fill_position++;
					end
					if (last) begin
						entry_len[stored_count] = fill_position;
						stored_count++;
					end
				end
				if (last)
					fill_position = 0;
				return;
			end
			if (query_len < DIM) begin
				query_vec[query_len] = value;
				query_len++;
			end
			if (!last)
				return;
			for (int i = 0; i < stored_count; i++) begin
				scores[i] = cosine_of(i);
				taken[i] = 0;
			end
			query_len = 0;
			want = (top_k > stored_count) ? stored_count : top_k;
			if (want == 0) begin
				h = '{6'd0, 16'sd0, 1'b0, 1'b1};
				pending_hits = {pending_hits, h};
				return;
			end
			// Strict comparison keeps the earlier entry on equal scores.
			for (int r = 0; r < want; r++) begin
				best = -1;
				for (int i = 0; i < stored_count; i++)
					if (!taken[i] && (best < 0 || scores[i] > scores[best]))
						best = i;
				taken[best] = 1;
				h.entry_index = best[5:0];
				h.score = scores[best];
				h.hit_valid = 1'b1;
				h.last_res = (r + 1 == want);
				pending_hits = {pending_hits, h};
			end
		endfunction

		function void check_hit(logic [23:0] data, logic user, logic last);
			hit_t want;
			if (pending_hits.size() == 0) begin
				$error("unexpected result transfer: tdata=%h tuser=%b tlast=%b",
					data, user, last);
				errors++;
				return;
			end
			want = pending_hits.pop_front();
			if (data[5:0] !== want.entry_index) begin
				$error("entry_index: expected %0d, got %0d", want.entry_index, data[5:0]);
				errors++;
			end
			if ($signed(data[21:6]) !== want.score) begin
				$error("score: expected %0d, got %0d", want.score, $signed(data[21:6]));
				errors++;
			end
			if (user !== want.hit_valid) begin
				$error("hit_valid: expected %b, got %b", want.hit_valid, user);
				errors++;
			end
			if (last !== want.last_res) begin
				$error("last_res: expected %b, got %b", want.last_res, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // [15:0] value, [22:16] top_k, [23] zero
	logic        s_axis_tuser = 1'b0;  // [0] command
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // [5:0] entry_index, [21:6] score, [23:22] zero
	logic        m_axis_tuser;  // [0] hit_valid
	logic        m_axis_tlast;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	topk_search_scoreboard board = new();

	cosine_topk_vector_search u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// The watchdog ends a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: values read in the active region of the edge are the ones
	// that were present before it, so a transfer is seen exactly once.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_hit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Sends one component transfer. Idle cycles are inserted first, and
	// tvalid stays high across back-to-back transfers.
	task automatic send_component(logic cmd, logic signed [15:0] value, logic last,
			logic [6:0] top_k);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tlast <= last;
		s_axis_tdata <= {1'b0, top_k, value};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_transfer(cmd, value, last, top_k);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return ($urandom_range(1)) ? 16'sd0 : -16'sd1;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic int pick_length();
		return ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
	endfunction

	function automatic logic [6:0] pick_top_k();
		case ($urandom_range(7))
			0: return 7'd64;
			1: return 7'd0;
			2: return 7'($urandom_range(64));
			default: return 7'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int entry_left, query_left;
		logic is_query;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a query on an empty store gives the single no-hit result.
		send_component(CMD_QUERY, 16'sh7FFF, 1'b1, 7'd3);
		// Entries: full-scale, most negative, zero norm, and a mixed one.
		send_component(CMD_ENTRY, 16'sh7FFF, 1'b0, 7'd0);
		send_component(CMD_ENTRY, 16'sh7FFF, 1'b1, 7'd0);
		send_component(CMD_ENTRY, 16'sh8000, 1'b0, 7'd0);
		send_component(CMD_ENTRY, 16'sd0, 1'b1, 7'd0);
		send_component(CMD_ENTRY, 16'sd0, 1'b0, 7'd0);
		send_component(CMD_ENTRY, 16'sd0, 1'b1, 7'd0);
		send_component(CMD_ENTRY, 16'sd100, 1'b0, 7'd0);
		send_component(CMD_ENTRY, -16'sd200, 1'b0, 7'd0);
		send_component(CMD_ENTRY, 16'sd300, 1'b1, 7'd0);
		// An exact match saturates; top_k beyond the store is clamped.
		send_component(CMD_QUERY, 16'sh7FFF, 1'b0, 7'd0);
		send_component(CMD_QUERY, 16'sh7FFF, 1'b1, 7'd64);
		// top_k of zero on a populated store is also a no-hit query.
		send_component(CMD_QUERY, 16'sd5, 1'b1, 7'd0);
		// Entry and query components interleave freely.
		send_component(CMD_QUERY, 16'sh8000, 1'b0, 7'd0);
		send_component(CMD_ENTRY, -16'sd7, 1'b0, 7'd0);
		send_component(CMD_QUERY, 16'sh7FFF, 1'b0, 7'd0);
		send_component(CMD_ENTRY, 16'sd9, 1'b1, 7'd0);
		send_component(CMD_QUERY, 16'sd5, 1'b1, 7'd2);

		// Random part: two independent vector streams, advanced at random, so
		// that long vectors overflow DIM and the store eventually fills.
		entry_left = pick_length();
		query_left = pick_length();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n * 4 / RANDOM_ITEMS)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 55; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 55; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			is_query = ($urandom_range(99) < 35);
			if (is_query) begin
				query_left--;
				send_component(CMD_QUERY, pick_value(), query_left == 0, pick_top_k());
				if (query_left == 0)
					query_left = pick_length();
			end else begin
				entry_left--;
				send_component(CMD_ENTRY, pick_value(), entry_left == 0,
					7'($urandom_range(127)));
				if (entry_left == 0)
					entry_left = pick_length();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
